// ----- hw/rtl/cordic_sin_cos_rotation_macros.svh -----
// Assertion macros shared by the checker of the sine and cosine block.
`ifndef CORDIC_SIN_COS_ROTATION_MACROS_SVH
`define CORDIC_SIN_COS_ROTATION_MACROS_SVH

// Implication checked on every rising clock edge, muted while reset is low.
`define CSC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: ante -> cons");

// Implication whose consequence is checked in the cycle after the antecedent.
`define CSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: ante => cons");

`endif

// ----- hw/rtl/csc_pkg.sv -----
// Package with the types, widths and constants of the sine and cosine block.
package csc_pkg;

  // Field widths of the request and result.
  localparam int ANGLE_W = 15;
  localparam int OUT_W   = 16;

  // Datapath widths: coordinates and residual angle are scaled by 2^16.
  localparam int XY_W   = 19;
  localparam int Z_W    = 19;
  localparam int ATAN_W = 16;
  localparam int IDX_W  = 4;

  // Gain compensation and output rounding.
  localparam int GAIN_W      = 16;
  localparam int PROD_W      = XY_W + GAIN_W + 1;
  localparam int ROUND_SHIFT = 18;
  localparam logic [GAIN_W-1:0] GainQ16 = 16'd39797;
  localparam int OutMax = 16384;

  // Start value of the x coordinate, 1.0 scaled by 2^16.
  localparam logic signed [XY_W-1:0] XStart = XY_W'(65536);

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROT,
    ST_FIN
  } csc_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } csc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_iter;
  } csc_status_t;

  // Arc tangent of 2^-idx scaled by 2^16, rounded to nearest.
  function automatic logic [ATAN_W-1:0] atan_lut(input logic [IDX_W-1:0] idx);
    logic [ATAN_W-1:0] val;
    unique case (idx)
      4'd0:    val = 16'd51472;
      4'd1:    val = 16'd30385;
      4'd2:    val = 16'd16055;
      4'd3:    val = 16'd8150;
      4'd4:    val = 16'd4091;
      4'd5:    val = 16'd2047;
      4'd6:    val = 16'd1024;
      4'd7:    val = 16'd512;
      4'd8:    val = 16'd256;
      4'd9:    val = 16'd128;
      4'd10:   val = 16'd64;
      4'd11:   val = 16'd32;
      4'd12:   val = 16'd16;
      4'd13:   val = 16'd8;
      4'd14:   val = 16'd4;
      default: val = 16'd2;
    endcase
    return val;
  endfunction

endpackage

// ----- hw/rtl/csc_ctrl.sv -----
// Controller state machine that sequences the micro-rotations and the output register.
module csc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  csc_pkg::csc_status_t status_i,
  output csc_pkg::csc_cmd_t    cmd_o
);
  import csc_pkg::*;

  csc_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // State and output valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          state_d    = ST_ROT;
        end
      end
      ST_ROT: begin
        cmd_o.step = 1'b1;
        if (status_i.last_iter) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // Wait until the output register is empty or is being emptied.
        if (!out_valid_q || m_axis_tready) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // A new result fills the output register; a taken result empties it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid_q;

endmodule

// ----- hw/rtl/csc_datapath.sv -----
// Datapath with the rotation registers, iteration counter, gain stage and output register.
module csc_datapath #(
  parameter int ITERATIONS = 13
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  csc_pkg::csc_cmd_t                   cmd_i,
  output csc_pkg::csc_status_t                status_o,
  input  logic signed [csc_pkg::ANGLE_W-1:0]  angle_i,
  output logic signed [csc_pkg::OUT_W-1:0]    cos_value_o,
  output logic signed [csc_pkg::OUT_W-1:0]    sin_value_o
);
  import csc_pkg::*;

  localparam int CNT_W = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;

  logic signed [XY_W-1:0] x_q, x_d, y_q, y_d;
  logic signed [Z_W-1:0]  z_q, z_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic signed [OUT_W-1:0] cos_q, sin_q;
  logic signed [XY_W-1:0] dx, dy;
  logic signed [Z_W-1:0]  atan_val;

  // Multiply by the gain, round half up and saturate to plus or minus one.
  function automatic logic signed [OUT_W-1:0] scale(input logic signed [XY_W-1:0] v);
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] res;
    logic signed [PROD_W-1:0] sat_hi;
    logic signed [PROD_W-1:0] sat_lo;
    sat_hi = PROD_W'(OutMax);
    sat_lo = -PROD_W'(OutMax);
    prod   = v * $signed({1'b0, GainQ16});
    res    = (prod + (PROD_W'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
    if (res > sat_hi) begin
      res = sat_hi;
    end else if (res < sat_lo) begin
      res = sat_lo;
    end
    return OUT_W'(res);
  endfunction

  // Shifted terms and table angle of the current step.
  assign dx       = y_q >>> cnt_q;
  assign dy       = x_q >>> cnt_q;
  assign atan_val = $signed(Z_W'(atan_lut(IDX_W'(cnt_q))));

  // Load the start vector or apply one micro-rotation.
  always_comb begin
    x_d   = x_q;
    y_d   = y_q;
    z_d   = z_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      x_d   = XStart;
      y_d   = '0;
      z_d   = Z_W'($signed({angle_i, 3'b000}));
      cnt_d = '0;
    end else if (cmd_i.step) begin
      if (!z_q[Z_W-1]) begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - atan_val;
      end else begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + atan_val;
      end
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  // Working registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q   <= '0;
      y_q   <= '0;
      z_q   <= '0;
      cnt_q <= '0;
    end else begin
      x_q   <= x_d;
      y_q   <= y_d;
      z_q   <= z_d;
      cnt_q <= cnt_d;
    end
  end

  // Output register, loaded with the scaled results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q <= '0;
      sin_q <= '0;
    end else if (cmd_i.finish) begin
      cos_q <= scale(x_q);
      sin_q <= scale(y_q);
    end
  end

  assign status_o.last_iter = (cnt_q == CNT_W'(ITERATIONS - 1));
  assign cos_value_o        = cos_q;
  assign sin_value_o        = sin_q;

endmodule

// ----- hw/rtl/cordic_sin_cos_rotation.sv -----
// Top level of the CORDIC sine and cosine block.
// Usage:
//   The slave channel takes one request: an angle in radians, Q2.13, meant
//   for plus or minus pi/2. The master channel returns one result per
//   request: the cosine and sine, each Q2.14 and saturated to plus or minus one.
//   A request is accepted only while the block is idle. It then runs
//   ITERATIONS shift-add micro-rotations, one per clock, and then the gain
//   multiply, rounding and saturation into the output register.
//   The result shows on the master channel in the same cycle in which the
//   block is idle again and can take the next request; the single shared
//   rotation unit takes a new request only once the last one has left it.
//   If the receiver stalls, the result waits in the output register while
//   the next request is already taken and rotated; only the final gain step
//   waits for the output register to empty.
//   Reset clears the controller and the output valid; no request is pending.
module cordic_sin_cos_rotation #(
  parameter int ITERATIONS = 13
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [14:0] angle, [15] zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // [15:0] cos_value, [31:16] sin_value
);
  import csc_pkg::*;

  csc_cmd_t    cmd;
  csc_status_t status;
  logic signed [OUT_W-1:0] cos_value;
  logic signed [OUT_W-1:0] sin_value;

  // Sequencer.
  csc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  // Rotation unit and output register.
  csc_datapath #(
    .ITERATIONS (ITERATIONS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .angle_i     ($signed(s_axis_tdata[ANGLE_W-1:0])),
    .cos_value_o (cos_value),
    .sin_value_o (sin_value)
  );

  assign m_axis_tdata = {sin_value, cos_value};

endmodule

// ----- hw/rtl/csc_checker.sv -----
// Port-level checker of the sine and cosine block and its bind statement.
`include "cordic_sin_cos_rotation_macros.svh"

module csc_checker #(
  parameter int ITERATIONS = 13
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  logic               in_req;
  logic signed [15:0] cos_res;
  logic signed [15:0] sin_res;
  logic               cos_ok;
  logic               sin_ok;

  assign in_req  = s_axis_tvalid && s_axis_tready;
  assign cos_res = $signed(m_axis_tdata[15:0]);
  assign sin_res = $signed(m_axis_tdata[31:16]);
  assign cos_ok  = (cos_res <= 16'sd16384) && (cos_res >= -16'sd16384);
  assign sin_ok  = (sin_res <= 16'sd16384) && (sin_res >= -16'sd16384);

  // The block is busy right after it takes a request.
  `CSC_ASSERT_NEXT(a_busy_after_req, in_req, !s_axis_tready)

  // A fresh result follows its request after the rotation steps and the finish state.
  `CSC_ASSERT_IMPL(a_latency, $rose(m_axis_tvalid), $past(in_req, ITERATIONS + 2))

  // A stalled result stays put.
  `CSC_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // Both outputs stay within plus or minus one.
  `CSC_ASSERT_IMPL(a_range, m_axis_tvalid, cos_ok && sin_ok)

endmodule

bind cordic_sin_cos_rotation csc_checker #(
  .ITERATIONS (ITERATIONS)
) u_csc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
